// ===== design/srtl_pkg.sv =====
package srtl_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;

    localparam int COUNT_W  = 9;
    localparam int SLOT_W   = 8;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;

    // s_tdata: slot, model_id, range_start, range_length, query_strip
    localparam int IN_DATA_W  = 136;
    // m_tdata: hit_index, hit_start, hit_length
    localparam int OUT_DATA_W = 72;

    typedef enum logic [STATUS_W-1:0] {
        ST_WRITTEN = 2'd0,
        ST_FOUND   = 2'd1,
        ST_MISS    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        MODE_WRITE  = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    typedef struct packed {
        logic    capture;
        logic    write;
        logic    init;
        logic    rd_en;
        logic    rd_last;
        logic    step;
        logic    check;
        logic    set_res;
        status_t res_code;
        logic    load_out;
    } srtl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  cnt_zero;
        logic  range_open;
        logic  lo_zero;
        logic  out_free;
    } srtl_stat_t;

endpackage

// ===== design/srtl_ctrl.sv =====
module srtl_ctrl
    import srtl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  srtl_stat_t st,
    output srtl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_INIT,
        S_ISSUE,
        S_PROBE,
        S_CHECK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.res_code = ST_WRITTEN;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                // captured mode decides the path
                if (st.mode == MODE_WRITE)
                begin
                    cmd.write    = 1'b1;
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_WRITTEN;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init = 1'b1;
                if (st.cnt_zero)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_EMPTY;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (st.range_open)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_PROBE;
                end
                else if (st.lo_zero)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_MISS;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_last = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_PROBE:
            begin
                cmd.step   = 1'b1;
                state_next = S_ISSUE;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> st.out_free)
        else $error("result loaded while output register still full");

    a_step_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> $past(cmd.rd_en && !cmd.rd_last))
        else $error("search step without a probe read the cycle before");

    a_check_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.check |-> $past(cmd.rd_en && cmd.rd_last))
        else $error("range check without the final read the cycle before");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken while an item is in flight");
`endif

endmodule

// ===== design/srtl_dp.sv =====
module srtl_dp
    import srtl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser,
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata,
    input  srtl_cmd_t             cmd,
    output srtl_stat_t            st
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // table, one word per field, undefined until written
    logic [WORD_W-1:0] model_mem  [TABLE_DEPTH];
    logic [WORD_W-1:0] start_mem  [TABLE_DEPTH];
    logic [WORD_W-1:0] length_mem [TABLE_DEPTH];

    logic [COUNT_W-1:0] fill_count_reg;

    mode_t             mode_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [WORD_W-1:0] model_reg;
    logic [WORD_W-1:0] start_reg;
    logic [WORD_W-1:0] length_reg;
    logic [WORD_W-1:0] strip_reg;

    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hi_reg;
    logic [CW-1:0] mid_reg;

    logic [WORD_W-1:0] rd_model_reg;
    logic [WORD_W-1:0] rd_start_reg;
    logic [WORD_W-1:0] rd_length_reg;

    status_t            res_status_reg;
    logic [INDEX_W-1:0] res_index_reg;
    logic [WORD_W-1:0]  res_start_reg;
    logic [WORD_W-1:0]  res_length_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [WORD_W-1:0]  out_start_reg;
    logic [WORD_W-1:0]  out_length_reg;

    logic [CW-1:0]     count_sat;
    logic [CW-1:0]     mid;
    logic [CW-1:0]     lo_dec;
    logic [CW-1:0]     rd_ptr;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_in_range;
    logic              go_right;
    logic              hit;
    logic [WORD_W-1:0] strip_off;
    logic [WORD_W-1:0] mid_wide;

    assign count_sat = (32'(fill_count_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                : CW'(fill_count_reg);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_dec   = lo_reg - CW'(1);
    assign rd_ptr   = cmd.rd_last ? lo_dec : mid;
    assign rd_addr  = AW'(rd_ptr);
    assign wr_addr  = AW'(slot_reg);
    assign wr_in_range = (32'(slot_reg) < 32'(TABLE_DEPTH));

    assign go_right = (rd_model_reg < model_reg) ||
                      ((rd_model_reg == model_reg) && (rd_start_reg <= strip_reg));

    // unsigned offset test; a range that runs past the top strip does not wrap to low strips
    assign strip_off = strip_reg - rd_start_reg;
    assign hit = (rd_model_reg == model_reg) && (strip_reg >= rd_start_reg) &&
                 (strip_off < rd_length_reg);
    assign mid_wide = 32'(mid_reg);

    assign st.mode       = mode_reg;
    assign st.cnt_zero   = (count_sat == '0);
    assign st.range_open = (lo_reg < hi_reg);
    assign st.lo_zero    = (lo_reg == '0);
    assign st.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_length_reg, out_start_reg, out_index_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_in_range)
        begin
            model_mem[wr_addr]  <= model_reg;
            start_mem[wr_addr]  <= start_reg;
            length_mem[wr_addr] <= length_reg;
        end
        if (cmd.rd_en)
        begin
            rd_model_reg  <= model_mem[rd_addr];
            rd_start_reg  <= start_mem[rd_addr];
            rd_length_reg <= length_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode_t'(s_tuser);
            slot_reg   <= s_tdata[7:0];
            model_reg  <= s_tdata[39:8];
            start_reg  <= s_tdata[71:40];
            length_reg <= s_tdata[103:72];
            strip_reg  <= s_tdata[135:104];
        end
        if (cmd.rd_en)
        begin
            mid_reg <= rd_ptr;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_code;
            res_index_reg  <= '0;
            res_start_reg  <= '0;
            res_length_reg <= '0;
        end
        else if (cmd.check)
        begin
            res_status_reg <= hit ? ST_FOUND : ST_MISS;
            res_index_reg  <= hit ? mid_wide[INDEX_W-1:0] : '0;
            res_start_reg  <= hit ? rd_start_reg : '0;
            res_length_reg <= hit ? rd_length_reg : '0;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_start_reg  <= res_start_reg;
            out_length_reg <= res_length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fill_count_reg <= cfg_wdata;
            end
            if (cmd.init)
            begin
                lo_reg <= '0;
                hi_reg <= count_sat;
            end
            else if (cmd.step)
            begin
                if (go_right)
                begin
                    lo_reg <= mid_reg + CW'(1);
                end
                else
                begin
                    hi_reg <= mid_reg;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search window inverted");

    a_window_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hi_reg) <= 32'(TABLE_DEPTH))
        else $error("search window beyond table depth");
`endif

endmodule

// ===== design/sorted_range_table_lookup_core.sv =====
// A lookup runs a binary search, one probe at a time. Each probe is one
// registered read of the single table port. One item at a time: the next beat
// is taken once the result is in the output register. Reset clears control
// state, the output valid and the fill count; table contents stay undefined.
module sorted_range_table_lookup_core
    import srtl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // slot[7:0], model_id[39:8], range_start[71:40], range_length[103:72],
    // query_strip[135:104]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit_index[7:0], hit_start[39:8], hit_length[71:40]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   m_tuser,
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata
);

    srtl_cmd_t  cmd;
    srtl_stat_t st;

    srtl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    srtl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import srtl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        status_t     status;
        logic [7:0]  index;
        logic [31:0] start;
        logic [31:0] len;
    } strip_answer_t;

    // typed rows only ever carry written/empty answers, so index and range are zero
    typedef struct packed {
        logic    typed;
        status_t status;
    } pinned_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    // for ROW_CFG the new fill count sits in len
    typedef struct packed {
        row_kind_t   kind;
        mode_t       mode;
        logic [7:0]  slot;
        logic [31:0] model;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] strip;
        logic        typed;
        status_t     status;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // slot, model_id, range_start, range_length, query_strip
    logic [IN_DATA_W-1:0]  s_tdata;
    // mode
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // hit_index, hit_start, hit_length
    logic [OUT_DATA_W-1:0] m_tdata;
    // status
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_we;
    logic [COUNT_W-1:0]    cfg_wdata;

    // shadow of the strip table and the count register
    logic [31:0]        tbl_model [TABLE_DEPTH_DEFAULT];
    logic [31:0]        tbl_start [TABLE_DEPTH_DEFAULT];
    logic [31:0]        tbl_len   [TABLE_DEPTH_DEFAULT];
    logic [COUNT_W-1:0] tbl_count;

    strip_answer_t expected_answers [$];
    pinned_t       pinned_q [$];
    dir_row_t      dir_rows [$];

    int unsigned count_plan [12] = '{1, 2, 5, 13, 40, 256, 511, 0, 3, 100, 300, 9};

    int beats_sent;
    int results_seen;
    int errors;
    int cycle_count;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_len;

    sorted_range_table_lookup_core #(
        .TABLE_DEPTH(TABLE_DEPTH_DEFAULT)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic strip_answer_t table_answer(input mode_t md, input logic [7:0] sl,
                                                   input logic [31:0] mdl, st, ln, sp);
        strip_answer_t r;
        int unsigned   n;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        int unsigned   k;
        r = '0;
        if (md == MODE_WRITE)
        begin
            tbl_model[sl] = mdl;
            tbl_start[sl] = st;
            tbl_len[sl]   = ln;
            r.status = ST_WRITTEN;
            return r;
        end
        n = (tbl_count > TABLE_DEPTH_DEFAULT) ? TABLE_DEPTH_DEFAULT : tbl_count;
        if (n == 0)
        begin
            r.status = ST_EMPTY;
            return r;
        end
        // last entry with (model, start) <= (mdl, sp)
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (tbl_model[mid[7:0]] < mdl ||
                (tbl_model[mid[7:0]] == mdl && tbl_start[mid[7:0]] <= sp))
                lo = mid + 1;
            else
                hi = mid;
        end
        r.status = ST_MISS;
        if (lo > 0)
        begin
            k = lo - 1;
            if (tbl_model[k[7:0]] == mdl && sp >= tbl_start[k[7:0]] &&
                (sp - tbl_start[k[7:0]]) < tbl_len[k[7:0]])
            begin
                r.status = ST_FOUND;
                r.index  = k[7:0];
                r.start  = tbl_start[k[7:0]];
                r.len    = tbl_len[k[7:0]];
            end
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want_v, got_v);
        if (got_v !== want_v)
        begin
            $display("%0t ns: %s expected 0x%08h actual 0x%08h", $time, what, want_v, got_v);
            errors++;
        end
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input mode_t md, input logic [7:0] sl,
                             input logic [31:0] mdl, st, ln, sp,
                             input logic typed, input status_t typed_status);
        int gap;
        pinned_t pin;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin.typed  = typed;
        pin.status = typed_status;
        pinned_q.push_back(pin);
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {sp, ln, st, mdl, sl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_seen != beats_sent)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_count(input logic [COUNT_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // predictor and scoreboard, both on the rising edge
    always @(posedge clk)
    begin
        strip_answer_t want;
        pinned_t       pin;
        if (rst_n)
        begin
            if (cfg_we)
                tbl_count = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                pin  = pinned_q.pop_front();
                want = table_answer(mode_t'(s_tuser), s_tdata[7:0], s_tdata[39:8],
                                    s_tdata[71:40], s_tdata[103:72], s_tdata[135:104]);
                if (pin.typed)
                begin
                    want = '0;
                    want.status = pin.status;
                end
                expected_answers.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_answers.size() == 0)
                begin
                    $display("%0t ns: result expected none actual status %0d data 0x%018h",
                             $time, m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("hit_index", 32'(want.index), 32'(m_tdata[7:0]));
                    check_field("hit_start", want.start, m_tdata[39:8]);
                    check_field("hit_length", want.len, m_tdata[71:40]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_len != 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_len - 1) @(negedge clk);
                rx_hold_len = 0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned k;
        logic [31:0] m;
        logic [31:0] s;
        logic [31:0] l;
        logic [31:0] mdl;
        logic [31:0] st;
        logic [31:0] ln;
        logic [31:0] sp;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        tbl_count    = '0;
        beats_sent   = 0;
        results_seen = 0;
        errors       = 0;
        cycle_count  = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_len  = 0;

        dir_rows = '{
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_EMPTY},
            '{ROW_BEAT, MODE_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b1, ST_EMPTY},
            '{ROW_BEAT, MODE_WRITE, 8'd0, 32'd5, 32'd100, 32'd10, 32'd0, 1'b1, ST_WRITTEN},
            // zero-length entry
            '{ROW_BEAT, MODE_WRITE, 8'd1, 32'd5, 32'd200, 32'd0, 32'hFFFF_FFFF, 1'b1,
              ST_WRITTEN},
            '{ROW_BEAT, MODE_WRITE, 8'd2, 32'd7, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_WRITTEN},
            // range runs past the top of the strip space
            '{ROW_BEAT, MODE_WRITE, 8'd3, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd0,
              1'b1, ST_WRITTEN},
            '{ROW_BEAT, MODE_WRITE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
              1'b1, ST_WRITTEN},
            '{ROW_CFG, MODE_WRITE, 8'd0, 32'd0, 32'd0, 32'd1, 32'd0, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd5, 32'd0, 32'd0, 32'd100, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd5, 32'd0, 32'd0, 32'd109, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd5, 32'd0, 32'd0, 32'd110, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd5, 32'd0, 32'd0, 32'd99, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd4, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, ST_WRITTEN},
            '{ROW_CFG, MODE_WRITE, 8'd0, 32'd0, 32'd0, 32'd4, 32'd0, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd5, 32'd0, 32'd0, 32'd205, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd5, 32'd0, 32'd0, 32'd200, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd7, 32'd0, 32'd0, 32'd0, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd7, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0,
              ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FEFF, 1'b0,
              ST_WRITTEN},
            '{ROW_CFG, MODE_WRITE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, ST_WRITTEN},
            '{ROW_BEAT, MODE_LOOKUP, 8'd0, 32'd5, 32'd0, 32'd0, 32'd100, 1'b1, ST_EMPTY}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                set_count(dir_rows[i].len[COUNT_W-1:0]);
            else
                send_beat(dir_rows[i].mode, dir_rows[i].slot, dir_rows[i].model,
                          dir_rows[i].start, dir_rows[i].len, dir_rows[i].strip,
                          dir_rows[i].typed, dir_rows[i].status);
        end

        for (int p = 0; p < 12; p++)
        begin
            case (p % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 82;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 82;
                end
                default:
                begin
                    tx_idle_pct  = 11;
                    rx_stall_pct = 11;
                end
            endcase
            n = (count_plan[p] > TABLE_DEPTH_DEFAULT) ? TABLE_DEPTH_DEFAULT : count_plan[p];

            // fresh sorted table in slots 0..n-1: models rise, ranges do not overlap
            m = $urandom_range(0, 32'h7FFF_FFFF);
            s = $urandom_range(0, 32'h7FFF_FFFF);
            for (int i = 0; i < int'(n); i++)
            begin
                if (i > 0 && $urandom_range(0, 3) == 0)
                begin
                    m = m + $urandom_range(1, 32'h0010_0000);
                    s = $urandom_range(0, 32'h7FFF_FFFF);
                end
                l = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 2000);
                send_beat(MODE_WRITE, 8'(i), m, s, l, $urandom, 1'b0, ST_WRITTEN);
                s = s + l + $urandom_range(0, 3);
            end
            set_count(9'(count_plan[p]));

            for (int i = 0; i < 70; i++)
            begin
                if (p == 4 && i == 10)
                    rx_hold_len = 250;
                if (i == 35)
                    drain();
                if (n == 0 || $urandom_range(0, 99) < 15)
                begin
                    if ($urandom_range(0, 2) == 0)
                        send_beat(MODE_WRITE, 8'($urandom), $urandom, $urandom, $urandom,
                                  $urandom, 1'b0, ST_WRITTEN);
                    else
                        send_beat(MODE_LOOKUP, 8'($urandom), $urandom, $urandom, $urandom,
                                  $urandom, 1'b0, ST_WRITTEN);
                end
                else
                begin
                    k   = $urandom_range(0, n - 1);
                    mdl = tbl_model[k[7:0]];
                    st  = tbl_start[k[7:0]];
                    ln  = tbl_len[k[7:0]];
                    case ($urandom_range(0, 6))
                        0: sp = st + ((ln == 0) ? 32'd0 : ($urandom % ln));
                        1: sp = st;
                        2: sp = st + ln - 1;
                        3: sp = st + ln;
                        4: sp = st - 1;
                        5: sp = $urandom;
                        default:
                        begin
                            mdl = mdl + 1;
                            sp  = st;
                        end
                    endcase
                    send_beat(MODE_LOOKUP, 8'($urandom), mdl, $urandom, $urandom, sp,
                              1'b0, ST_WRITTEN);
                end
            end
        end

        drain();
        repeat (30) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
